FILE: rtl/servo_gesture_sequencer_core_defines.svh
// ---------------------------------------------------------------------------
// Servo gesture sequencer assertion macros
// Short forms for the concurrent checks in the sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef SERVO_GESTURE_SEQUENCER_CORE_DEFINES_SVH
`define SERVO_GESTURE_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SGS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sgs check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SGS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sgs check failed");

`endif

FILE: rtl/sgs_pkg.sv
// ---------------------------------------------------------------------------
// Servo gesture sequencer package
// Opcodes, gesture step table, result types shared by the sequencer RTL.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgs_pkg;

  localparam int NUM_GESTURES   = 4;
  localparam int MAX_STEPS      = 4;
  localparam int TIMER_BITS     = 9;
  localparam int TABLE_GESTURES = 4;

  localparam int ANGLE_W  = 8;
  localparam int DUR_W    = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [ANGLE_W-1:0] MAX_ANGLE       = 8'd180;
  localparam logic [ANGLE_W-1:0] ROT_CENTER_RST  = 8'd90;
  localparam logic [ANGLE_W-1:0] TILT_CENTER_RST = 8'd57;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_ROT_CENTER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_CENTER = 2'd1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PLAY   = 2'd1,
    OP_CANCEL = 2'd2
  } opcode_t;

  // Offset marker for "keep current angle"
  localparam logic signed [7:0] NO_MOVE = 8'sh7F;

  // Step table, indexed by {gesture, step}
  localparam logic signed [7:0] ROT_OFS [16] = '{
    NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE,
    NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE,
    8'sd22,  -8'sd22, 8'sd12,  8'sd0,
    8'sd0,   NO_MOVE, NO_MOVE, NO_MOVE
  };

  localparam logic signed [7:0] TILT_OFS [16] = '{
    8'sd13,  -8'sd9,  8'sd0,   NO_MOVE,
    8'sd15,  -8'sd12, 8'sd10,  8'sd0,
    NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE,
    8'sd0,   NO_MOVE, NO_MOVE, NO_MOVE
  };

  localparam logic [DUR_W-1:0] DUR_MS [16] = '{
    9'd220, 9'd280, 9'd200, 9'd0,
    9'd200, 9'd240, 9'd200, 9'd220,
    9'd260, 9'd340, 9'd260, 9'd260,
    9'd400, 9'd0,   9'd0,   9'd0
  };

  localparam logic [2:0] GEST_LEN [4] = '{3'd3, 3'd4, 3'd4, 3'd1};

  typedef struct packed {
    logic               rot_valid;
    logic [ANGLE_W-1:0] rot_angle;
    logic               tilt_valid;
    logic [ANGLE_W-1:0] tilt_angle;
  } cmd_t;

  typedef struct packed {
    logic accepted;
    cmd_t cmd;
    logic busy;
    logic finished;
  } res_t;

  // Step count of a gesture, capped by MAX_STEPS
  function automatic logic [2:0] gest_len(input logic [1:0] g);
    logic [2:0] n;
    n = GEST_LEN[g];
    if (int'(n) > MAX_STEPS) n = 3'(MAX_STEPS);
    return n;
  endfunction

endpackage

FILE: rtl/sgs_cmd_gen.sv
// ---------------------------------------------------------------------------
// Servo gesture command generator
// Looks up one step and forms saturated rotation and tilt commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgs_cmd_gen import sgs_pkg::*; (
  input  logic               en,
  input  logic [1:0]         gest,
  input  logic [1:0]         step,
  input  logic [ANGLE_W-1:0] rot_center,
  input  logic [ANGLE_W-1:0] tilt_center,
  output cmd_t               cmd
);

  logic signed [7:0] rot_ofs;
  logic signed [7:0] tilt_ofs;

  // center + offset, clamped to 0..180
  function automatic logic [ANGLE_W-1:0] sat_angle(input logic [ANGLE_W-1:0] c,
                                                   input logic signed [7:0] o);
    logic signed [9:0] sum;
    sum = $signed({2'b00, c}) + 10'(o);
    if (sum < 0) return '0;
    if (sum > $signed({2'b00, MAX_ANGLE})) return MAX_ANGLE;
    return sum[ANGLE_W-1:0];
  endfunction

  assign rot_ofs  = ROT_OFS[{gest, step}];
  assign tilt_ofs = TILT_OFS[{gest, step}];

  always_comb begin
    cmd = '0;
    if (en && rot_ofs != NO_MOVE) begin
      cmd.rot_valid = 1'b1;
      cmd.rot_angle = sat_angle(rot_center, rot_ofs);
    end
    if (en && tilt_ofs != NO_MOVE) begin
      cmd.tilt_valid = 1'b1;
      cmd.tilt_angle = sat_angle(tilt_center, tilt_ofs);
    end
  end

endmodule

FILE: rtl/sgs_seq.sv
// ---------------------------------------------------------------------------
// Servo gesture step sequencer
// Holds the playback state and works out one result per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgs_seq import sgs_pkg::*; #(
  parameter int TIMER_BITS_P = TIMER_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [1:0]         op,
  input  logic [2:0]         id,
  input  logic [ANGLE_W-1:0] rot_center,
  input  logic [ANGLE_W-1:0] tilt_center,
  output res_t               res
);

  logic                    playing, playing_next;
  logic [1:0]              gest, gest_next;
  logic [1:0]              step, step_next;
  logic [TIMER_BITS_P-1:0] elapsed, elapsed_next;

  logic                    issue_en;
  logic [1:0]              issue_gest;
  logic [1:0]              issue_step;
  logic [TIMER_BITS_P-1:0] el_inc;
  logic [2:0]              step_inc;
  cmd_t                    cmd;

  assign el_inc   = (elapsed == '1) ? elapsed : elapsed + TIMER_BITS_P'(1);
  assign step_inc = {1'b0, step} + 3'd1;

  always_comb begin
    playing_next = playing;
    gest_next    = gest;
    step_next    = step;
    elapsed_next = elapsed;
    issue_en     = 1'b0;
    issue_gest   = gest;
    issue_step   = step_inc[1:0];
    res          = '0;
    case (op)
      OP_PLAY: begin
        if (int'(id) < NUM_GESTURES && int'(id) < TABLE_GESTURES) begin
          playing_next = 1'b1;
          gest_next    = id[1:0];
          step_next    = '0;
          elapsed_next = '0;
          res.accepted = 1'b1;
          issue_en     = 1'b1;
          issue_gest   = id[1:0];
          issue_step   = '0;
        end
      end
      OP_CANCEL: begin
        playing_next = 1'b0;
      end
      OP_TICK: begin
        if (playing) begin
          elapsed_next = el_inc;
          if (el_inc >= TIMER_BITS_P'(DUR_MS[{gest, step}])) begin
            if (step_inc >= gest_len(gest)) begin
              playing_next = 1'b0;
              res.finished = 1'b1;
            end else begin
              step_next    = step_inc[1:0];
              elapsed_next = '0;
              issue_en     = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.cmd  = cmd;
    res.busy = playing_next;
  end

  sgs_cmd_gen u_cmd_gen (
    .en          (issue_en),
    .gest        (issue_gest),
    .step        (issue_step),
    .rot_center  (rot_center),
    .tilt_center (tilt_center),
    .cmd         (cmd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      playing <= 1'b0;
      gest    <= '0;
      step    <= '0;
      elapsed <= '0;
    end else if (fire) begin
      playing <= playing_next;
      gest    <= gest_next;
      step    <= step_next;
      elapsed <= elapsed_next;
    end
  end

endmodule

FILE: rtl/servo_gesture_sequencer_core.sv
// ---------------------------------------------------------------------------
// Servo gesture sequencer core
// Plays built-in timed head gestures as saturated rotation/tilt commands.
// ---------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  -------  ---  --------------------  ----------------------------------------
//  in       in   in_valid / in_ready   opcode, gesture_id
//  out      out  out_valid / out_ready accepted, rotation_*, tilt_*, busy_res,
//                                      finished
//  cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
//  Path: a request is held in the input register, then its result lands in
//  the output register, where out_valid rises; a stall can hold it between.
//  Throughput: one request per cycle while the output is not stalled; the
//  step table lookup, timer compare and angle add/clamp all fit between
//  those two registers. Stalls: out_ready low with a result waiting freezes
//  the output register and a full input register; in_ready drops only when
//  the input register is full and the output can't drain.
//  Reset: sync, active high; idle, centers back to 90 / 57; cfg always ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "servo_gesture_sequencer_core_defines.svh"

module servo_gesture_sequencer_core import sgs_pkg::*; #(
  parameter int TIMER_BITS_P = TIMER_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic [2:0]           gesture_id,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 accepted,
  output logic                 rotation_valid,
  output logic [ANGLE_W-1:0]   rotation_angle,
  output logic                 tilt_valid,
  output logic [ANGLE_W-1:0]   tilt_angle,
  output logic                 busy_res,
  output logic                 finished,
  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ANGLE_W-1:0]   cfg_data
);

  // Input register stage
  logic       s1_valid;
  logic [1:0] s1_op;
  logic [2:0] s1_id;

  // Pipeline advance: output register free or draining this cycle
  logic advance;
  logic fire;

  // Center registers
  logic [ANGLE_W-1:0] rot_center;
  logic [ANGLE_W-1:0] tilt_center;

  res_t res_comb;
  res_t res_q;

  assign advance   = !out_valid || out_ready;
  assign fire      = s1_valid && advance;
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op <= opcode;
      s1_id <= gesture_id;
    end
  end

  // Config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_center  <= ROT_CENTER_RST;
      tilt_center <= TILT_CENTER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROT_CENTER:  rot_center  <= cfg_data;
        REG_TILT_CENTER: tilt_center <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // State update and result forming happen as the request leaves stage 1
  sgs_seq #(
    .TIMER_BITS_P (TIMER_BITS_P)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .op          (s1_op),
    .id          (s1_id),
    .rot_center  (rot_center),
    .tilt_center (tilt_center),
    .res         (res_comb)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_comb;
    end
  end

  assign accepted       = res_q.accepted;
  assign rotation_valid = res_q.cmd.rot_valid;
  assign rotation_angle = res_q.cmd.rot_angle;
  assign tilt_valid     = res_q.cmd.tilt_valid;
  assign tilt_angle     = res_q.cmd.tilt_angle;
  assign busy_res       = res_q.busy;
  assign finished       = res_q.finished;

  // A started gesture is playing afterwards
  `SGS_ASSERT_NOW(a_accept_busy, out_valid && accepted, busy_res)
  // Finishing leaves the block idle with no servo command
  `SGS_ASSERT_NOW(a_finish_idle, out_valid && finished,
                  !busy_res && !rotation_valid && !tilt_valid && !accepted)
  // Commanded angles stay in the servo range
  `SGS_ASSERT_NOW(a_rot_range, out_valid && rotation_valid, rotation_angle <= MAX_ANGLE)
  `SGS_ASSERT_NOW(a_tilt_range, out_valid && tilt_valid, tilt_angle <= MAX_ANGLE)
  // An accepted request occupies the input stage next cycle
  `SGS_ASSERT_NEXT(a_in_capture, in_valid && in_ready, s1_valid)

endmodule

FILE: tb/sv/servo_gesture_sequencer_core_tb.sv
// ---------------------------------------------------------------------------
// Servo gesture sequencer core testbench
// Drives tick / play / cancel / opcode-three requests and register writes into the
// core, predicts each result from an independent model of the gesture table,
// and compares every result field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_gesture_sequencer_core_tb import sgs_pkg::*; ();

  // Opcode three has no name in the package; the core must treat it as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Register indexes with nothing behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Gesture table, written out independently. HOLD_ANGLE marks "keep the
  // current angle", i.e. no command on that axis.
  localparam int PLAN_GESTURES = 4;
  localparam int HOLD_ANGLE    = 999;

  // Request budget for the whole run
  localparam int REQUEST_BUDGET = 1150;

  localparam int ROT_PLAN [4][4] = '{
    '{HOLD_ANGLE, HOLD_ANGLE, HOLD_ANGLE, HOLD_ANGLE},
    '{HOLD_ANGLE, HOLD_ANGLE, HOLD_ANGLE, HOLD_ANGLE},
    '{22, -22, 12, 0},
    '{0, HOLD_ANGLE, HOLD_ANGLE, HOLD_ANGLE}
  };
  localparam int TILT_PLAN [4][4] = '{
    '{13, -9, 0, HOLD_ANGLE},
    '{15, -12, 10, 0},
    '{HOLD_ANGLE, HOLD_ANGLE, HOLD_ANGLE, HOLD_ANGLE},
    '{0, HOLD_ANGLE, HOLD_ANGLE, HOLD_ANGLE}
  };
  localparam int DWELL_MS [4][4] = '{
    '{220, 280, 200, 0},
    '{200, 240, 200, 220},
    '{260, 340, 260, 260},
    '{400, 0, 0, 0}
  };
  localparam int STEP_COUNT [4] = '{3, 4, 4, 1};

  // Centers that stress the clamp: both ends, just past 180, all ones
  localparam logic [ANGLE_W-1:0] CENTER_PICKS [8] = '{
    8'd0, 8'd1, 8'd57, 8'd90, 8'd127, 8'd180, 8'd181, 8'd255
  };

  typedef struct {
    bit                   reg_write;
    logic [1:0]           op;
    logic [2:0]           gid;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [ANGLE_W-1:0]   reg_val;
  } servo_request_t;

  typedef struct {
    logic               accepted;
    logic               rot_valid;
    logic [ANGLE_W-1:0] rot_angle;
    logic               tilt_valid;
    logic [ANGLE_W-1:0] tilt_angle;
    logic               busy;
    logic               finished;
  } servo_response_t;

  // DUT connections; every input has a known value from time zero
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           opcode = 2'd0;
  logic [2:0]           gesture_id = 3'd0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 accepted;
  logic                 rotation_valid;
  logic [ANGLE_W-1:0]   rotation_angle;
  logic                 tilt_valid;
  logic [ANGLE_W-1:0]   tilt_angle;
  logic                 busy_res;
  logic                 finished;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ANGLE_W-1:0]   cfg_data = '0;

  servo_request_t  request_backlog[$];    // requests not yet presented
  servo_response_t pending_responses[$];  // predicted, not yet seen at the output

  // Predicted core state
  logic [ANGLE_W-1:0]    model_rot_center  = ROT_CENTER_RST;
  logic [ANGLE_W-1:0]    model_tilt_center = TILT_CENTER_RST;
  logic                  model_playing     = 1'b0;
  logic [1:0]            model_gesture     = '0;
  logic [1:0]            model_step        = '0;
  logic [TIMER_BITS-1:0] model_elapsed     = '0;

  bit  mismatch_seen = 1'b0;
  int  cycle_count   = 0;
  int  cycle_limit   = 1000000;

  servo_gesture_sequencer_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .gesture_id     (gesture_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .rotation_valid (rotation_valid),
    .rotation_angle (rotation_angle),
    .tilt_valid     (tilt_valid),
    .tilt_angle     (tilt_angle),
    .busy_res       (busy_res),
    .finished       (finished),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int steps_in(input logic [1:0] g);
    return (STEP_COUNT[g] > MAX_STEPS) ? MAX_STEPS : STEP_COUNT[g];
  endfunction

  // Total ticks a gesture needs from play to finished
  function automatic int gesture_ms(input logic [1:0] g);
    int sum;
    sum = 0;
    for (int s = 0; s < steps_in(g); s++) sum += DWELL_MS[g][s];
    return sum;
  endfunction

  function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] center,
                                                     input int ofs);
    int v;
    v = int'(center) + ofs;
    if (v < 0) v = 0;
    if (v > 180) v = 180;
    return v[ANGLE_W-1:0];
  endfunction

  // Servo commands of the current step; untouched axis stays 0
  function automatic void step_commands(inout servo_response_t r);
    if (ROT_PLAN[model_gesture][model_step] != HOLD_ANGLE) begin
      r.rot_valid = 1'b1;
      r.rot_angle = clamp_angle(model_rot_center, ROT_PLAN[model_gesture][model_step]);
    end
    if (TILT_PLAN[model_gesture][model_step] != HOLD_ANGLE) begin
      r.tilt_valid = 1'b1;
      r.tilt_angle = clamp_angle(model_tilt_center, TILT_PLAN[model_gesture][model_step]);
    end
  endfunction

  // Advances the predicted state by one request and queues its result
  task automatic predict_servo_response(input logic [1:0] op, input logic [2:0] gid);
    servo_response_t r;
    r = '{default: '0};
    case (op)
      OP_PLAY: begin
        if (int'(gid) < NUM_GESTURES && int'(gid) < PLAN_GESTURES) begin
          model_playing = 1'b1;
          model_gesture = gid[1:0];
          model_step    = '0;
          model_elapsed = '0;
          r.accepted    = 1'b1;
          step_commands(r);
        end
      end
      OP_CANCEL: model_playing = 1'b0;
      OP_TICK: begin
        if (model_playing) begin
          if (model_elapsed != '1) model_elapsed = model_elapsed + 1'b1;
          if (int'(model_elapsed) >= DWELL_MS[model_gesture][model_step]) begin
            if (int'(model_step) + 1 >= steps_in(model_gesture)) begin
              model_playing = 1'b0;
              r.finished    = 1'b1;
            end else begin
              model_step    = model_step + 1'b1;
              model_elapsed = '0;
              step_commands(r);
            end
          end
        end
      end
      default: ;  // opcode three: no effect
    endcase
    r.busy = model_playing;
    pending_responses.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  task automatic add_request(input logic [1:0] op, input logic [2:0] gid);
    servo_request_t q;
    q = '{reg_write: 1'b0, op: op, gid: gid, reg_idx: '0, reg_val: '0};
    request_backlog.push_back(q);
  endtask

  task automatic add_reg_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [ANGLE_W-1:0] val);
    servo_request_t q;
    q = '{reg_write: 1'b1, op: '0, gid: '0, reg_idx: idx, reg_val: val};
    request_backlog.push_back(q);
  endtask

  // Play a gesture and tick it to completion; stray rejected plays and
  // opcode-three requests are mixed in since they must not disturb timing
  task automatic add_full_run(input logic [1:0] g);
    int ticks;
    ticks = gesture_ms(g);
    add_request(OP_PLAY, {1'b0, g});
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 63) == 0) begin
        if ($urandom_range(0, 1) == 0) add_request(OP_UNUSED, 3'($urandom_range(0, 7)));
        else add_request(OP_PLAY, 3'($urandom_range(4, 7)));
      end
      add_request(OP_TICK, 3'($urandom_range(0, 7)));
    end
    for (int i = $urandom_range(1, 3); i > 0; i--) add_request(OP_TICK, '0);
  endtask

  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 19) == 0) burst = !burst;
    return burst ? 0 : int'($urandom_range(0, 11));
  endfunction

  initial begin
    int phase;
    int seg;
    int boundary;
    int ticks;
    int room;
    int pick;
    int last_step;
    logic [1:0] g;

    // -- Directed part --
    add_request(OP_TICK, 3'd0);        // tick while idle
    add_request(OP_UNUSED, 3'd7);      // opcode three while idle
    add_request(OP_CANCEL, 3'd0);      // cancel while idle
    add_request(OP_PLAY, 3'd4);        // unknown ids
    add_request(OP_PLAY, 3'd5);
    add_request(OP_PLAY, 3'd6);
    add_request(OP_PLAY, 3'd7);
    add_request(OP_PLAY, 3'd0);        // wake ack at reset centers
    add_request(OP_TICK, 3'd0);
    add_request(OP_UNUSED, 3'd3);      // opcode three while playing
    add_request(OP_PLAY, 3'd7);        // rejected while playing: keeps going
    add_request(OP_PLAY, 3'd1);        // restart with another gesture
    add_request(OP_PLAY, 3'd2);
    add_request(OP_PLAY, 3'd3);
    add_request(OP_CANCEL, 3'd0);
    add_request(OP_TICK, 3'd0);
    add_reg_write(REG_ROT_CENTER, 8'd255);   // centers above 180
    add_reg_write(REG_TILT_CENTER, 8'd255);
    add_request(OP_PLAY, 3'd3);
    add_request(OP_PLAY, 3'd1);
    add_reg_write(REG_ROT_CENTER, 8'd0);
    add_reg_write(REG_TILT_CENTER, 8'd0);
    add_request(OP_PLAY, 3'd2);
    add_request(OP_PLAY, 3'd0);
    add_reg_write(REG_SPARE_A, 8'hAA);       // unmapped indexes are dropped
    add_reg_write(REG_SPARE_B, 8'h55);
    add_request(OP_PLAY, 3'd3);
    add_request(OP_CANCEL, 3'd0);

    // -- Random part: phases of center settings, sized to the budget --
    phase = 0;
    while (request_backlog.size() < REQUEST_BUDGET) begin
      case (phase)
        0: begin
          add_reg_write(REG_ROT_CENTER, 8'd0);
          add_reg_write(REG_TILT_CENTER, 8'd0);
        end
        1: begin
          add_reg_write(REG_ROT_CENTER, 8'd255);
          add_reg_write(REG_TILT_CENTER, 8'd180);
        end
        2: begin
          add_reg_write(REG_ROT_CENTER, 8'd180);
          add_reg_write(REG_TILT_CENTER, 8'd1);
        end
        default: begin
          add_reg_write(REG_ROT_CENTER, ($urandom_range(0, 1) == 0) ?
                        CENTER_PICKS[$urandom_range(0, 7)] : 8'($urandom_range(0, 255)));
          add_reg_write(REG_TILT_CENTER, ($urandom_range(0, 1) == 0) ?
                        CENTER_PICKS[$urandom_range(0, 7)] : 8'($urandom_range(0, 255)));
          if ($urandom_range(0, 3) == 0)
            add_reg_write(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                          8'($urandom_range(0, 255)));
        end
      endcase
      // Shortest gesture played to its end once
      if (phase == 0) add_full_run(2'd3);

      for (seg = 0; seg < 3; seg++) begin
        room = REQUEST_BUDGET - int'(request_backlog.size());
        g    = 2'($urandom_range(0, 3));
        pick = int'($urandom_range(0, 9));
        if (pick <= 2 && gesture_ms(g) + gesture_ms(g) / 32 + 8 <= room) begin
          add_full_run(g);
        end else if (pick <= 6 &&
                     DWELL_MS[g][0] + DWELL_MS[g][0] / 64 + 16 <= room) begin
          // Cut a gesture short near a step boundary, then break it off
          last_step = int'($urandom_range(0, steps_in(g) - 1));
          boundary  = 0;
          for (int s = 0; s <= last_step; s++) boundary += DWELL_MS[g][s];
          while (last_step > 0 && boundary + boundary / 64 + 16 > room) begin
            boundary -= DWELL_MS[g][last_step];
            last_step--;
          end
          ticks = boundary + int'($urandom_range(0, 4)) - 2;
          add_request(OP_PLAY, {1'b0, g});
          for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 99) == 0) add_request(OP_PLAY, 3'($urandom_range(4, 7)));
            add_request(OP_TICK, '0);
          end
          case ($urandom_range(0, 3))
            0: add_request(OP_CANCEL, 3'($urandom_range(0, 7)));
            1: add_request(OP_PLAY, 3'($urandom_range(0, 3)));
            2: begin
              add_request(OP_PLAY, 3'($urandom_range(4, 7)));
              add_request(OP_CANCEL, '0);
            end
            default: ;
          endcase
        end else begin
          // Noise: any opcode, any id
          for (int i = $urandom_range(1, 8); i > 0; i--)
            add_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
        end
      end
      phase++;
    end

    // Worst case per request: longest sender gap, longest receiver stall,
    // pipeline latency; then a wide margin
    cycle_limit = request_backlog.size() * (11 + 11 + 6) * 4 + 20000;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything presented, every result seen, then a few cycles
    while (request_backlog.size() != 0 || in_valid || cfg_valid) @(posedge clk);
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (!mismatch_seen) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: request and register write channels
  // ---------------------------------------------------------------------------
  int send_gap   = 0;
  bit send_burst = 1'b0;

  always @(posedge clk) begin : drive_requests
    bit in_hold;
    bit cfg_hold;
    bit in_next;
    bit cfg_next;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      send_gap  = 0;
    end else begin
      in_hold  = in_valid && !in_ready;
      cfg_hold = cfg_valid && !cfg_ready;
      in_next  = in_hold;
      cfg_next = cfg_hold;

      // Ports still hold the accepted payload at this edge
      if (in_valid && in_ready) begin
        predict_servo_response(opcode, gesture_id);
        send_gap = draw_wait(send_burst);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROT_CENTER:  model_rot_center  = cfg_data;
          REG_TILT_CENTER: model_tilt_center = cfg_data;
          default: ;
        endcase
        send_gap = draw_wait(send_burst);
      end

      if (!in_hold && !cfg_hold && request_backlog.size() != 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!request_backlog[0].reg_write) begin
          opcode     <= request_backlog[0].op;
          gesture_id <= request_backlog[0].gid;
          in_next    = 1'b1;
          void'(request_backlog.pop_front());
        end else if (pending_responses.size() == 0) begin
          // Register writes only once every outstanding result is back
          cfg_index <= request_backlog[0].reg_idx;
          cfg_data  <= request_backlog[0].reg_val;
          cfg_next  = 1'b1;
          void'(request_backlog.pop_front());
        end
      end
      in_valid  <= in_next;
      cfg_valid <= cfg_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: result channel with random back-pressure
  // ---------------------------------------------------------------------------
  int  stall_left = 0;
  bit  recv_burst = 1'b0;

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_seen = 1'b1;
    end
  endtask

  always @(posedge clk) begin : watch_results
    servo_response_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_responses.size() == 0) begin
          $error("result with no request outstanding");
          mismatch_seen = 1'b1;
        end else begin
          want = pending_responses.pop_front();
          check_field("accepted", want.accepted, accepted);
          check_field("rotation_valid", want.rot_valid, rotation_valid);
          check_field("rotation_angle", want.rot_angle, rotation_angle);
          check_field("tilt_valid", want.tilt_valid, tilt_valid);
          check_field("tilt_angle", want.tilt_angle, tilt_angle);
          check_field("busy_res", want.busy, busy_res);
          check_field("finished", want.finished, finished);
        end
        stall_left = draw_wait(recv_burst);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sgs_pkg.sv
rtl/sgs_cmd_gen.sv
rtl/sgs_seq.sv
rtl/servo_gesture_sequencer_core.sv
tb/sv/servo_gesture_sequencer_core_tb.sv
